[src/pidl_pkg.sv]
// pidl_pkg: shared types and constants for the positional insert/delete list.
// Used by every module of the block and by its checker. No dependencies.
`default_nettype none
package pidl_pkg;

	localparam int DEPTH_DEF  = 16;
	localparam int DATA_W_DEF = 32;
	localparam int POS_W      = 4;
	localparam int CAP_W      = 5;
	localparam int APB_DW     = 32;
	localparam int ADDR_W     = 3;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	// register index sits at paddr[2]
	localparam logic REG_CAP = 1'b0;

	typedef enum logic [2:0] {
		OP_APPEND  = 3'd0,
		OP_INSERT  = 3'd1,
		OP_ERASE   = 3'd2,
		OP_REPLACE = 3'd3,
		OP_READ    = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE   = 2'd0,
		ST_BADPOS = 2'd1,
		ST_FULL   = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		CMD_NONE,
		CMD_APPEND,
		CMD_INSERT,
		CMD_ERASE,
		CMD_REPLACE
	} cell_cmd_t;

	typedef struct packed {
		cell_cmd_t cmd;
		status_t   st;
		logic      rd_ok;
	} dec_t;

endpackage
`default_nettype wire

[src/pidl_cell.sv]
// pidl_cell: one list entry. Each cycle it holds its word, loads, clears or takes a neighbor's word.
// Depends on pidl_pkg.
`default_nettype none
module pidl_cell #(
	parameter int DATA_W = pidl_pkg::DATA_W_DEF,
	parameter int CMP_W  = 5,
	parameter int INDEX  = 0
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire pidl_pkg::cell_cmd_t   cmd,
	input  wire logic [CMP_W-1:0]      pos,
	input  wire logic [CMP_W-1:0]      cnt,
	input  wire logic [DATA_W-1:0]     wr_data,
	input  wire logic [DATA_W-1:0]     left_data,
	input  wire logic [DATA_W-1:0]     right_data,
	output logic      [DATA_W-1:0]     data_q
);
	import pidl_pkg::*;

	localparam logic [CMP_W-1:0] IDX = CMP_W'(INDEX);

	logic [CMP_W-1:0]  cnt_m1;
	logic [DATA_W-1:0] data_d;

	assign cnt_m1 = cnt - CMP_W'(1);

	always_comb begin
		data_d = data_q;
		case (cmd)
			CMD_APPEND: begin
				if (IDX == cnt) data_d = wr_data;
			end
			CMD_INSERT: begin
				if (IDX == pos) data_d = wr_data;
				else if (IDX > pos && IDX <= cnt) data_d = left_data;
			end
			CMD_ERASE: begin
				if (IDX == cnt_m1) data_d = '0;
				else if (IDX >= pos && IDX < cnt) data_d = right_data;
			end
			CMD_REPLACE: begin
				if (IDX == pos) data_d = wr_data;
				else if (IDX >= cnt && IDX < pos) data_d = '0;
			end
			default: data_d = data_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) data_q <= '0;
		else data_q <= data_d;
	end

endmodule
`default_nettype wire

[src/pidl_dec.sv]
// pidl_dec: request decode. Status, next count and the command broadcast to the cells.
// Depends on pidl_pkg.
`default_nettype none
module pidl_dec #(
	parameter int CMP_W = 5
) (
	input  wire logic [2:0]          operation,
	input  wire logic [CMP_W-1:0]    pos,
	input  wire logic [CMP_W-1:0]    cnt,
	input  wire logic [CMP_W-1:0]    cap,
	output pidl_pkg::dec_t           dec,
	output logic      [CMP_W-1:0]    cnt_next
);
	import pidl_pkg::*;

	always_comb begin
		dec.cmd   = CMD_NONE;
		dec.st    = ST_DONE;
		dec.rd_ok = 1'b0;
		cnt_next  = cnt;
		case (op_t'(operation))
			OP_APPEND: begin
				if (cnt >= cap) dec.st = ST_FULL;
				else begin
					dec.cmd  = CMD_APPEND;
					cnt_next = cnt + CMP_W'(1);
				end
			end
			OP_INSERT: begin
				if (cnt >= cap) dec.st = ST_FULL;
				else if (pos > cnt) dec.st = ST_BADPOS;
				else begin
					dec.cmd  = CMD_INSERT;
					cnt_next = cnt + CMP_W'(1);
				end
			end
			OP_ERASE: begin
				if (pos >= cnt) dec.st = ST_BADPOS;
				else begin
					dec.cmd  = CMD_ERASE;
					cnt_next = cnt - CMP_W'(1);
				end
			end
			OP_REPLACE: begin
				if (pos >= cap) dec.st = ST_BADPOS;
				else begin
					dec.cmd = CMD_REPLACE;
					if (pos >= cnt) cnt_next = pos + CMP_W'(1);
				end
			end
			OP_READ: begin
				if (pos >= cnt) dec.st = ST_BADPOS;
				else dec.rd_ok = 1'b1;
			end
			default: dec.st = ST_BADPOS;
		endcase
	end

endmodule
`default_nettype wire

[src/positional_insert_delete_list_top.sv]
// positional_insert_delete_list_top: ordered list of signed words held in a row of cells.
// Depends on pidl_pkg, pidl_cell, pidl_dec.
//
//   channel  direction  handshake           payload
//   in       sink       in_valid/in_stall   operation, position, value
//   out      source     out_valid/out_stall read_value, element_count, status
//   cfg      APB        psel/penable/pready paddr, pwdata, prdata
//
// One request per cycle while in_stall is low: every cell updates in the cycle a request is taken,
// and the result appears in the output register on the next cycle.
// in_stall is high only while a result waits in the output register under out_stall.
// Reset clears the list to zero, the count to zero and the capacity to 16.
`default_nettype none
module positional_insert_delete_list_top #(
	parameter int DEPTH  = pidl_pkg::DEPTH_DEF,
	parameter int DATA_W = pidl_pkg::DATA_W_DEF,
	localparam int CNT_W = $clog2(DEPTH + 1)
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [2:0]                    operation,
	input  wire logic [pidl_pkg::POS_W-1:0]    position,
	input  wire logic signed [DATA_W-1:0]      value,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic signed [DATA_W-1:0]           read_value,
	output logic [CNT_W-1:0]                   element_count,
	output logic [1:0]                         status,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [pidl_pkg::ADDR_W-1:0]   paddr,
	input  wire logic [pidl_pkg::APB_DW-1:0]   pwdata,
	output logic      [pidl_pkg::APB_DW-1:0]   prdata,
	output logic                               pready
);
	import pidl_pkg::*;

	localparam int MAX_A = (CNT_W > POS_W) ? CNT_W : POS_W;
	localparam int CMP_W = (MAX_A > CAP_W) ? MAX_A : CAP_W;
	localparam int IDX_W = $clog2(DEPTH);

	logic [CAP_W-1:0]  cap_q;
	logic [CNT_W-1:0]  count_q;
	logic [CMP_W-1:0]  cap_x, cap_eff, new_x, new_eff, cnt_x, pos_x, cnt_next;
	logic              cfg_wr, accept;
	dec_t              dec;
	cell_cmd_t         cell_cmd;
	logic [DATA_W-1:0] cell_data [DEPTH];
	logic [DATA_W-1:0] rd_word;

	logic                     out_valid_q;
	logic [DATA_W-1:0]        read_value_q;
	logic [CNT_W-1:0]         element_count_q;
	logic [1:0]               status_q;

	// configuration
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & (paddr[2] == REG_CAP);
	assign prdata = (paddr[2] == REG_CAP) ? {{(APB_DW-CAP_W){1'b0}}, cap_q} : '0;

	assign cap_x   = CMP_W'(cap_q);
	assign cap_eff = (cap_x == '0) ? CMP_W'(1) :
	                 (cap_x > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : cap_x;
	assign new_x   = CMP_W'(pwdata[CAP_W-1:0]);
	assign new_eff = (new_x == '0) ? CMP_W'(1) :
	                 (new_x > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : new_x;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cap_q <= CAP_RESET;
		else if (cfg_wr) cap_q <= pwdata[CAP_W-1:0];
	end

	// request decode
	assign in_stall = out_valid_q & out_stall;
	assign accept   = in_valid & ~in_stall;
	assign cnt_x    = CMP_W'(count_q);
	assign pos_x    = CMP_W'(position);

	pidl_dec #(.CMP_W(CMP_W)) u_dec (
		.operation (operation),
		.pos       (pos_x),
		.cnt       (cnt_x),
		.cap       (cap_eff),
		.dec       (dec),
		.cnt_next  (cnt_next)
	);

	assign cell_cmd = accept ? dec.cmd : CMD_NONE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) count_q <= '0;
		else if (accept) count_q <= cnt_next[CNT_W-1:0];
		else if (cfg_wr && cnt_x > new_eff) count_q <= new_eff[CNT_W-1:0];
	end

	// cell row
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [DATA_W-1:0] left_w, right_w;
		if (i == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_left
			assign left_w = cell_data[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_right
			assign right_w = cell_data[i+1];
		end
		pidl_cell #(.DATA_W(DATA_W), .CMP_W(CMP_W), .INDEX(i)) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cell_cmd),
			.pos        (pos_x),
			.cnt        (cnt_x),
			.wr_data    (value),
			.left_data  (left_w),
			.right_data (right_w),
			.data_q     (cell_data[i])
		);
	end

	assign rd_word = dec.rd_ok ? cell_data[pos_x[IDX_W-1:0]] : '0;

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (accept) out_valid_q <= 1'b1;
		else if (!out_stall) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			read_value_q    <= rd_word;
			element_count_q <= cnt_next[CNT_W-1:0];
			status_q        <= dec.st;
		end
	end

	assign out_valid     = out_valid_q;
	assign read_value    = read_value_q;
	assign element_count = element_count_q;
	assign status        = status_q;

endmodule
`default_nettype wire

[src/pidl_check.sv]
// pidl_check: port-level checks for the list block, bound to the top level.
// Depends on pidl_pkg and positional_insert_delete_list_top.
`default_nettype none
module pidl_check #(
	parameter int DEPTH  = pidl_pkg::DEPTH_DEF,
	parameter int DATA_W = pidl_pkg::DATA_W_DEF,
	parameter int CNT_W  = $clog2(DEPTH + 1)
) (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              in_valid,
	input wire logic              in_stall,
	input wire logic              out_valid,
	input wire logic              out_stall,
	input wire logic [DATA_W-1:0] read_value,
	input wire logic [CNT_W-1:0]  element_count,
	input wire logic [1:0]        status
);
	import pidl_pkg::*;

	// a taken request always yields a result next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> out_valid)
		else $error("no result after accepted request");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(read_value) && $stable(status))
		else $error("stalled result changed");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_DONE |-> read_value == '0)
		else $error("failed request returned data");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> element_count <= CNT_W'(DEPTH) &&
			(status == ST_DONE || status == ST_BADPOS || status == ST_FULL))
		else $error("count or status out of range");

endmodule

bind positional_insert_delete_list_top pidl_check #(
	.DEPTH  (DEPTH),
	.DATA_W (DATA_W)
) u_pidl_check (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.read_value    (read_value),
	.element_count (element_count),
	.status        (status)
);
`default_nettype wire

[dv/tb.sv]
`timescale 1ns / 100ps
// tb: self-checking bench for positional_insert_delete_list_top. It predicts each
// result from its own copy of the list and count, and checks results in order.
// Depends on pidl_pkg and the block's RTL.
module tb;
	import pidl_pkg::*;

	localparam int LIST_DEPTH = DEPTH_DEF;
	localparam int CYCLE_LIMIT = 300000;
	localparam int LONG_HOLD = 80;
	localparam logic [ADDR_W-1:0] CAP_ADDR = {REG_CAP, 2'b00};
	localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
	localparam logic [2:0] OP_UNUSED_LAST = 3'd7;
	localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] WORD_MAX = 32'sh7FFF_FFFF;

	typedef struct {
		logic signed [31:0] rd_word;
		logic [4:0]         cnt;
		status_t            st;
	} list_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [2:0] operation = '0;
	logic [POS_W-1:0] position = '0;
	logic signed [31:0] value = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [31:0] read_value;
	logic [4:0] element_count;
	logic [1:0] status;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [APB_DW-1:0] pwdata = '0;
	logic [APB_DW-1:0] prdata;
	logic pready;

	logic signed [31:0] list_mem [LIST_DEPTH];
	int list_len = 0;
	logic [4:0] cap_reg = CAP_RESET;
	list_result_t expected_results [$];

	int fail_cnt = 0;
	int cycle_cnt = 0;
	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_req = 0;
	int hold_left = 0;

	positional_insert_delete_list_top DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.operation(operation), .position(position), .value(value),
		.out_valid(out_valid), .out_stall(out_stall),
		.read_value(read_value), .element_count(element_count), .status(status),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// receiver: random stall, or a long hold on request
	always @(posedge clk) begin
		if (hold_req != 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		list_result_t exp_r;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result: read_value %0d element_count %0d status %0d",
					read_value, element_count, status);
				fail_cnt++;
			end else begin
				exp_r = expected_results.pop_front();
				if (read_value !== exp_r.rd_word) begin
					$error("read_value: expected %0d, got %0d", exp_r.rd_word, read_value);
					fail_cnt++;
				end
				if (element_count !== exp_r.cnt) begin
					$error("element_count: expected %0d, got %0d", exp_r.cnt, element_count);
					fail_cnt++;
				end
				if (status !== exp_r.st) begin
					$error("status: expected %0d, got %0d", exp_r.st, status);
					fail_cnt++;
				end
			end
		end
	end

	function automatic int eff_cap();
		int c;
		c = cap_reg;
		if (c == 0) c = 1;
		if (c > LIST_DEPTH) c = LIST_DEPTH;
		return c;
	endfunction

	function automatic list_result_t apply_request(logic [2:0] op, logic [POS_W-1:0] pos,
			logic signed [31:0] val);
		list_result_t r;
		int lim;
		int p;
		lim = eff_cap();
		p = pos;
		r.rd_word = '0;
		r.st = ST_DONE;
		case (op)
			OP_APPEND: begin
				if (list_len >= lim) begin
					r.st = ST_FULL;
				end else begin
					list_mem[list_len] = val;
					list_len++;
				end
			end
			OP_INSERT: begin
				if (list_len >= lim) begin
					r.st = ST_FULL;
				end else if (p > list_len) begin
					r.st = ST_BADPOS;
				end else begin
					for (int i = list_len; i > p; i--) list_mem[i] = list_mem[i-1];
					list_mem[p] = val;
					list_len++;
				end
			end
			OP_ERASE: begin
				if (p >= list_len) begin
					r.st = ST_BADPOS;
				end else begin
					for (int i = p; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
					list_len--;
					list_mem[list_len] = '0;
				end
			end
			OP_REPLACE: begin
				if (p >= lim) begin
					r.st = ST_BADPOS;
				end else begin
					for (int i = list_len; i < p; i++) list_mem[i] = '0;
					list_mem[p] = val;
					if (p >= list_len) list_len = p + 1;
				end
			end
			OP_READ: begin
				if (p >= list_len) r.st = ST_BADPOS;
				else r.rd_word = list_mem[p];
			end
			default: r.st = ST_BADPOS;
		endcase
		r.cnt = list_len[4:0];
		return r;
	endfunction

	task automatic send_req(input logic [2:0] op, input logic [POS_W-1:0] pos,
			input logic signed [31:0] val);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		position <= pos;
		value <= val;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		expected_results.push_back(apply_request(op, pos, val));
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [4:0] cap);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= CAP_ADDR;
		pwdata <= {{(APB_DW-5){1'b0}}, cap};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		cap_reg = cap;
		if (list_len > eff_cap()) list_len = eff_cap();
	endtask

	function automatic logic signed [31:0] pick_word();
		case ($urandom_range(0, 19))
			0: return WORD_MIN;
			1: return WORD_MAX;
			2: return '0;
			3: return -32'sd1;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [POS_W-1:0] pick_pos(int hi);
		if (hi < 0 || $urandom_range(0, 4) == 0) return POS_W'($urandom_range(0, 15));
		if (hi > 15) hi = 15;
		return POS_W'($urandom_range(0, hi));
	endfunction

	task automatic send_random_req();
		int r;
		r = $urandom_range(0, 99);
		if (r < 22) send_req(OP_APPEND, POS_W'($urandom), pick_word());
		else if (r < 44) send_req(OP_INSERT, pick_pos(list_len), pick_word());
		else if (r < 64) send_req(OP_ERASE, pick_pos(list_len - 1), pick_word());
		else if (r < 76) send_req(OP_REPLACE, pick_pos(eff_cap() - 1), pick_word());
		else if (r < 96) send_req(OP_READ, pick_pos(list_len - 1), pick_word());
		else send_req(3'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST)),
			POS_W'($urandom), pick_word());
	endtask

	task automatic test_empty_list();
		send_req(OP_READ, 4'd0, '0);
		send_req(OP_ERASE, 4'd0, '0);
		send_req(OP_INSERT, 4'd1, WORD_MAX);
		for (int op = OP_UNUSED_FIRST; op <= OP_UNUSED_LAST; op++)
			send_req(3'(op), 4'hF, -32'sd1);
		wait_idle();
	endtask

	task automatic test_edit_ops();
		send_req(OP_APPEND, 4'd0, WORD_MIN);
		send_req(OP_APPEND, 4'd0, WORD_MAX);
		send_req(OP_INSERT, 4'd0, '0);
		send_req(OP_INSERT, 4'd3, -32'sd1);
		send_req(OP_INSERT, 4'd2, 32'sh5A5A_5A5A);
		for (int i = 0; i < 5; i++) send_req(OP_READ, POS_W'(i), '0);
		send_req(OP_REPLACE, 4'd1, 32'sh0F0F_0F0F);
		// replace past the end zero-fills the gap
		send_req(OP_REPLACE, 4'd9, 32'shA5A5_A5A5);
		send_req(OP_READ, 4'd7, '0);
		send_req(OP_READ, 4'd9, '0);
		send_req(OP_ERASE, 4'd0, '0);
		send_req(OP_ERASE, 4'd8, '0);
		send_req(OP_ERASE, 4'd15, '0);
		send_req(OP_REPLACE, 4'd15, WORD_MAX);
		send_req(OP_READ, 4'd15, '0);
		send_req(OP_APPEND, 4'd0, 32'sd1);
		send_req(OP_INSERT, 4'hF, 32'sd1);
		wait_idle();
	endtask

	task automatic test_capacity();
		write_capacity(5'd4);
		send_req(OP_INSERT, 4'hF, 32'sd2);
		send_req(OP_REPLACE, 4'd4, 32'sd3);
		send_req(OP_REPLACE, 4'd3, 32'sd4);
		send_req(OP_ERASE, 4'd3, '0);
		send_req(OP_INSERT, 4'd1, 32'sd5);
		send_req(OP_APPEND, 4'd0, 32'sd6);
		wait_idle();
		write_capacity(5'd2);
		send_req(OP_READ, 4'd1, '0);
		send_req(OP_READ, 4'd2, '0);
		wait_idle();
		write_capacity(5'd0);
		send_req(OP_APPEND, 4'd0, 32'sd7);
		send_req(OP_REPLACE, 4'd1, 32'sd8);
		send_req(OP_READ, 4'd0, '0);
		wait_idle();
		write_capacity(5'd31);
		send_req(OP_REPLACE, 4'd15, WORD_MIN);
		send_req(OP_APPEND, 4'd0, '0);
		wait_idle();
		write_capacity(5'd17);
		send_req(OP_READ, 4'd15, '0);
		wait_idle();
		write_capacity(5'd1);
		send_req(OP_INSERT, 4'd0, '0);
		wait_idle();
		write_capacity(CAP_RESET);
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0;
		stall_pct = 0;
		hold_req = LONG_HOLD;
		repeat (30) send_random_req();
		wait_idle();
		repeat (20) send_random_req();
		wait_idle();
	endtask

	task automatic test_random(input int n_items, input int idle_pct, input int st_pct);
		send_idle_pct = idle_pct;
		stall_pct = st_pct;
		for (int chunk = 0; chunk < 3; chunk++) begin
			case ($urandom_range(0, 3))
				0: write_capacity(CAP_RESET);
				1: write_capacity(5'($urandom_range(0, 31)));
				2: write_capacity(5'($urandom_range(8, 16)));
				default: write_capacity(5'($urandom_range(1, 4)));
			endcase
			repeat (n_items / 3) send_random_req();
			wait_idle();
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_list();
		test_edit_ops();
		test_capacity();
		test_backpressure();
		test_random(330, 0, 0);
		test_random(330, 54, 0);
		test_random(330, 0, 54);
		test_random(330, 21, 21);
		wait_idle();
		repeat (4) @(posedge clk);
		if (fail_cnt == 0 && expected_results.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
